>>> rtl/bblru_pkg.sv
package bblru_pkg;

    localparam int SLOTS = 32;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int MAX_KEY_BYTES = 4096;
    localparam int HEADER_BYTES = 4;

    localparam logic [2:0] KIND_PUT = 3'd0;
    localparam logic [2:0] KIND_GET = 3'd1;
    localparam logic [2:0] KIND_PROBE = 3'd2;
    localparam logic [2:0] KIND_REMOVE = 3'd3;
    localparam logic [2:0] KIND_CLEAR = 3'd4;

    // One slot of the index as held in the slot memory.
    typedef struct packed {
        logic [63:0] key;
        logic [32:0] bytes;
        logic [63:0] recency;
    } entry_t;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DECODE    = 7'b0000010,
        S_SCAN      = 7'b0000100,
        S_EVICT_CHK = 7'b0001000,
        S_EVICT_OUT = 7'b0010000,
        S_INSERT    = 7'b0100000,
        S_FINAL     = 7'b1000000
    } state_t;

endpackage

>>> rtl/byte_budget_lru_cache_index_top.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    kind, key, key_length, payload_length
// result    out        out_valid / out_stall  ok, evicted, evicted_key, entry_bytes,
//                                             total_bytes, entry_count, last
// config    in         cfg_valid / cfg_ready  cfg_data (byte budget)
//
// One item is worked on at a time. A lookup scans the slot memory one slot per cycle.
// A get, probe or remove runs decode, a scan and the final step; a put adds an eviction
// check, a scan and an eviction output per eviction, and the insert. Clear, unused kinds
// and rejected puts go from decode to the final step. The input is free again once the
// final result is loaded. Reset clears the valid bits, totals and recency counter, not
// the slot memory. A stalled result holds the block in an output step until it is taken.
module byte_budget_lru_cache_index_top
    import bblru_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [2:0]   kind,
    input  logic [63:0]  key,
    input  logic [12:0]  key_length,
    input  logic [31:0]  payload_length,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         ok,
    output logic         evicted,
    output logic [63:0]  evicted_key,
    output logic [32:0]  entry_bytes,
    output logic [38:0]  total_bytes,
    output logic [5:0]   entry_count,
    output logic         last,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [39:0]  cfg_data
);

    // Slot memory: key, charge and recency of every slot, one synchronous read port.
    entry_t mem [SLOTS];
    entry_t rd_data_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    entry_t mem_wdata;

    state_t state_reg, state_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [38:0] total_reg, total_next;
    logic [63:0] recency_reg, recency_next;
    logic [39:0] budget_reg;

    logic [2:0] kind_reg;
    logic [63:0] key_reg;
    logic [32:0] inc_reg;
    logic reject_reg;

    // Scan control: issue counter and the slot whose data returns this cycle.
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic pend_reg, pend_next;
    logic [SLOT_W-1:0] pend_idx_reg, pend_idx_next;
    logic lru_mode_reg, lru_mode_next;
    logic full_evict_reg, full_evict_next;
    logic hit_reg, hit_next;
    logic [SLOT_W-1:0] hit_idx_reg, hit_idx_next;
    entry_t hit_data_reg, hit_data_next;

    logic fin_ok_reg, fin_ok_next;
    logic [32:0] fin_bytes_reg, fin_bytes_next;

    logic out_valid_reg, out_valid_next;
    logic ok_reg, ok_next;
    logic evicted_reg, evicted_next;
    logic [63:0] evicted_key_reg, evicted_key_next;
    logic [32:0] entry_bytes_reg, entry_bytes_next;
    logic [38:0] total_bytes_reg, total_bytes_next;
    logic [CNT_W-1:0] entry_count_reg, entry_count_next;
    logic last_reg, last_next;

    logic emit_ok;
    logic scan_done;
    logic [SLOT_W-1:0] free_idx;
    logic [32:0] in_charge;
    logic in_accept;

    assign in_accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_charge = 33'(HEADER_BYTES) + {20'b0, key_length} + {1'b0, payload_length};
    // The result register may be loaded when it is empty or being emptied.
    assign emit_ok = !out_valid_reg || !out_stall;
    assign scan_done = (iss_reg == CNT_W'(SLOTS)) && !pend_reg;
    assign rd_addr = iss_reg[SLOT_W-1:0];

    assign out_valid = out_valid_reg;
    assign ok = ok_reg;
    assign evicted = evicted_reg;
    assign evicted_key = evicted_key_reg;
    assign entry_bytes = entry_bytes_reg;
    assign total_bytes = total_bytes_reg;
    assign entry_count = entry_count_reg;
    assign last = last_reg;

    // Lowest free slot; only used when at least one slot is free.
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        total_next = total_reg;
        recency_next = recency_reg;
        iss_next = iss_reg;
        pend_next = 1'b0;
        pend_idx_next = pend_idx_reg;
        lru_mode_next = lru_mode_reg;
        full_evict_next = full_evict_reg;
        hit_next = hit_reg;
        hit_idx_next = hit_idx_reg;
        hit_data_next = hit_data_reg;
        fin_ok_next = fin_ok_reg;
        fin_bytes_next = fin_bytes_reg;
        mem_we = 1'b0;
        mem_waddr = hit_idx_reg;
        mem_wdata = hit_data_reg;

        out_valid_next = out_valid_reg && out_stall;
        ok_next = ok_reg;
        evicted_next = evicted_reg;
        evicted_key_next = evicted_key_reg;
        entry_bytes_next = entry_bytes_reg;
        total_bytes_next = total_bytes_reg;
        entry_count_next = entry_count_reg;
        last_next = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // Default is a plain key lookup scan.
                iss_next = '0;
                hit_next = 1'b0;
                lru_mode_next = 1'b0;
                state_next = S_SCAN;
                fin_ok_next = 1'b0;
                fin_bytes_next = '0;
                unique case (kind_reg) inside
                    KIND_PUT:
                    begin
                        if (reject_reg)
                        begin
                            fin_bytes_next = inc_reg;
                            state_next = S_FINAL;
                        end
                    end
                    KIND_GET, KIND_PROBE, KIND_REMOVE:
                    begin
                    end
                    KIND_CLEAR:
                    begin
                        valid_next = '0;
                        count_next = '0;
                        total_next = '0;
                        fin_ok_next = 1'b1;
                        state_next = S_FINAL;
                    end
                    default:
                    begin
                        state_next = S_FINAL;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (iss_reg < CNT_W'(SLOTS))
                begin
                    pend_next = 1'b1;
                    pend_idx_next = iss_reg[SLOT_W-1:0];
                    iss_next = iss_reg + 1'b1;
                end
                if (pend_reg && valid_reg[pend_idx_reg])
                begin
                    if (lru_mode_reg)
                    begin
                        // Strict compare keeps the lowest slot on a recency tie.
                        if (!hit_reg || (rd_data_reg.recency < hit_data_reg.recency))
                        begin
                            hit_next = 1'b1;
                            hit_idx_next = pend_idx_reg;
                            hit_data_next = rd_data_reg;
                        end
                    end
                    else if (!hit_reg && (rd_data_reg.key == key_reg))
                    begin
                        hit_next = 1'b1;
                        hit_idx_next = pend_idx_reg;
                        hit_data_next = rd_data_reg;
                    end
                end
                if (scan_done)
                begin
                    if (lru_mode_reg)
                    begin
                        valid_next[hit_idx_reg] = 1'b0;
                        count_next = count_reg - 1'b1;
                        total_next = total_reg - {6'b0, hit_data_reg.bytes};
                        state_next = S_EVICT_OUT;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                        fin_ok_next = hit_reg;
                        fin_bytes_next = hit_reg ? hit_data_reg.bytes : 33'd0;
                        if (hit_reg &&
                            ((kind_reg == KIND_PUT) || (kind_reg == KIND_REMOVE)))
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            count_next = count_reg - 1'b1;
                            total_next = total_reg - {6'b0, hit_data_reg.bytes};
                        end
                        if (hit_reg && (kind_reg == KIND_GET))
                        begin
                            // Refresh recency: write the entry back with a new stamp.
                            mem_we = 1'b1;
                            mem_waddr = hit_idx_reg;
                            mem_wdata = hit_data_reg;
                            mem_wdata.recency = recency_reg;
                            recency_next = recency_reg + 64'd1;
                        end
                        if (kind_reg == KIND_PUT)
                        begin
                            state_next = S_EVICT_CHK;
                        end
                    end
                end
            end
            S_EVICT_CHK:
            begin
                iss_next = '0;
                hit_next = 1'b0;
                lru_mode_next = 1'b1;
                if ((budget_reg != '0) && (count_reg != '0) &&
                    (({1'b0, total_reg} + {7'b0, inc_reg}) > budget_reg))
                begin
                    full_evict_next = 1'b0;
                    state_next = S_SCAN;
                end
                else if (count_reg == CNT_W'(SLOTS))
                begin
                    full_evict_next = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_EVICT_OUT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    ok_next = 1'b0;
                    evicted_next = 1'b1;
                    evicted_key_next = hit_data_reg.key;
                    entry_bytes_next = hit_data_reg.bytes;
                    total_bytes_next = total_reg;
                    entry_count_next = count_reg;
                    last_next = 1'b0;
                    state_next = full_evict_reg ? S_INSERT : S_EVICT_CHK;
                end
            end
            S_INSERT:
            begin
                mem_we = 1'b1;
                mem_waddr = free_idx;
                mem_wdata.key = key_reg;
                mem_wdata.bytes = inc_reg;
                mem_wdata.recency = recency_reg;
                recency_next = recency_reg + 64'd1;
                valid_next[free_idx] = 1'b1;
                count_next = count_reg + 1'b1;
                total_next = total_reg + {6'b0, inc_reg};
                fin_ok_next = 1'b1;
                fin_bytes_next = inc_reg;
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    ok_next = fin_ok_reg;
                    evicted_next = 1'b0;
                    evicted_key_next = '0;
                    entry_bytes_next = fin_bytes_reg;
                    total_bytes_next = total_reg;
                    entry_count_next = count_reg;
                    last_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Slot memory. Scans never overlap a write: writes happen only when a scan ends
    // or outside scans, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
            total_reg <= '0;
            recency_reg <= '0;
            budget_reg <= '0;
            iss_reg <= '0;
            pend_reg <= 1'b0;
            lru_mode_reg <= 1'b0;
            full_evict_reg <= 1'b0;
            hit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            total_reg <= total_next;
            recency_reg <= recency_next;
            if (cfg_valid && cfg_ready)
            begin
                budget_reg <= cfg_data;
            end
            iss_reg <= iss_next;
            pend_reg <= pend_next;
            lru_mode_reg <= lru_mode_next;
            full_evict_reg <= full_evict_next;
            hit_reg <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg <= kind;
            key_reg <= key;
            inc_reg <= in_charge;
            reject_reg <= (key_length > 13'(MAX_KEY_BYTES)) ||
                          ((budget_reg != '0) && ({7'b0, in_charge} > budget_reg));
        end
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_data_reg <= hit_data_next;
        fin_ok_reg <= fin_ok_next;
        fin_bytes_reg <= fin_bytes_next;
        ok_reg <= ok_next;
        evicted_reg <= evicted_next;
        evicted_key_reg <= evicted_key_next;
        entry_bytes_reg <= entry_bytes_next;
        total_bytes_reg <= total_bytes_next;
        entry_count_reg <= entry_count_next;
        last_reg <= last_next;
    end

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("entry count disagrees with valid bits");

    a_empty_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (total_reg == '0))
        else $error("charged total nonzero with no entries");

    a_evict_has_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVICT_OUT) |-> hit_reg)
        else $error("eviction reported without a victim");

    a_no_write_mid_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !pend_reg)
        else $error("slot memory written while a scan read is outstanding");

    a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INSERT) |-> (count_reg < CNT_W'(SLOTS)))
        else $error("insert with every slot full");

endmodule

>>> tb/sv/byte_budget_lru_cache_index_top_tb.sv
`timescale 1ns / 1ps

// Testbench for the byte-budget LRU cache index.
// A directed table runs first, then random traffic over several budget settings.
// Every result transaction is checked against a behavioural model of the index, kept
// here alongside the stimulus, or against the answer written into a directed row.
module byte_budget_lru_cache_index_top_tb;
    import bblru_pkg::*;

    // Kinds 5 to 7 are not operations.  The block must answer them with a miss.
    localparam logic [2:0] KIND_SPARE_5 = 3'd5;
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    // This is the number of quiet cycles after which the run is declared hung.
    // The longest quiet stretch of a correct run is the pause before a budget write; a scan
    // between two transactions is far shorter, plus any receiver stall, so this limit leaves
    // a wide margin.
    localparam int HANG_LIMIT = 20000;
    localparam int KEY_POOL = 48;

    typedef struct {
        bit        ok;
        bit        evicted;
        bit [63:0] evicted_key;
        bit [32:0] entry_bytes;
        bit [38:0] total_bytes;
        bit [5:0]  entry_count;
        bit        last;
    } cache_result_t;

    typedef struct {
        bit [2:0]  kind;
        bit [63:0] key;
        bit [12:0] key_length;
        bit [31:0] payload_length;
        bit        typed;     // the expected result is written into the row
        bit        ok;
        bit [32:0] entry_bytes;
    } op_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  kind;
    logic [63:0] key;
    logic [12:0] key_length;
    logic [31:0] payload_length;
    logic        out_valid;
    logic        out_stall;
    logic        ok;
    logic        evicted;
    logic [63:0] evicted_key;
    logic [32:0] entry_bytes;
    logic [38:0] total_bytes;
    logic [5:0]  entry_count;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [39:0] cfg_data;

    byte_budget_lru_cache_index_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .key            (key),
        .key_length     (key_length),
        .payload_length (payload_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .evicted        (evicted),
        .evicted_key    (evicted_key),
        .entry_bytes    (entry_bytes),
        .total_bytes    (total_bytes),
        .entry_count    (entry_count),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // This is the model of the index: slot contents, recency stamps, the running
    // total and the current budget.
    bit            mdl_valid [SLOTS];
    bit [63:0]     mdl_key [SLOTS];
    bit [32:0]     mdl_bytes [SLOTS];
    bit [63:0]     mdl_stamp [SLOTS];
    bit [63:0]     mdl_clock;
    bit [38:0]     mdl_total;
    bit [39:0]     mdl_budget;

    cache_result_t pending_results[$];
    op_row_t       op_table[$];
    bit [63:0]     key_pool [KEY_POOL];

    int            error_count;
    int            send_gap_pct;
    int            recv_stall_pct;
    int            quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int live_entries();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (mdl_valid[i])
                n++;
        return n;
    endfunction

    function automatic int lookup_slot(bit [63:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (mdl_valid[i] && mdl_key[i] == k)
                return i;
        return -1;
    endfunction

    // The oldest stamp loses.  On a tie, the lowest slot index goes first.
    function automatic int oldest_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (mdl_valid[i] && (best < 0 || mdl_stamp[i] < mdl_stamp[best]))
                best = i;
        return best;
    endfunction

    task automatic push_result(bit r_ok, bit r_ev, bit [63:0] r_key, bit [32:0] r_bytes,
                               bit r_last);
        cache_result_t r;
        r.ok          = r_ok;
        r.evicted     = r_ev;
        r.evicted_key = r_key;
        r.entry_bytes = r_bytes;
        r.total_bytes = mdl_total;
        r.entry_count = 6'(live_entries());
        r.last        = r_last;
        pending_results.push_back(r);
    endtask

    task automatic evict_oldest();
        int v;
        v = oldest_slot();
        if (v >= 0)
        begin
            mdl_total    = mdl_total - 39'(mdl_bytes[v]);
            mdl_valid[v] = 1'b0;
            push_result(1'b0, 1'b1, mdl_key[v], mdl_bytes[v], 1'b0);
        end
    endtask

    // Applies one accepted transaction to the model.  The results it causes are
    // queued in order.
    task automatic apply_cache_op(bit [2:0] op, bit [63:0] k, bit [12:0] klen,
                                  bit [31:0] plen);
        bit [32:0] charge;
        bit [32:0] held;
        int        s;
        charge = 33'(HEADER_BYTES) + 33'(klen) + 33'(plen);
        case (op)
            KIND_PUT:
            begin
                if (klen > 13'(MAX_KEY_BYTES) ||
                    (mdl_budget != 0 && 40'(charge) > mdl_budget))
                begin
                    push_result(1'b0, 1'b0, 64'd0, charge, 1'b1);
                end
                else
                begin
                    s = lookup_slot(k);
                    if (s >= 0)
                    begin
                        mdl_total    = mdl_total - 39'(mdl_bytes[s]);
                        mdl_valid[s] = 1'b0;
                    end
                    if (mdl_budget != 0)
                        while (live_entries() > 0 &&
                               40'(mdl_total) + 40'(charge) > mdl_budget)
                            evict_oldest();
                    if (live_entries() >= SLOTS)
                        evict_oldest();
                    s = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!mdl_valid[i])
                            s = i;
                    if (s >= 0)
                    begin
                        mdl_valid[s] = 1'b1;
                        mdl_key[s]   = k;
                        mdl_bytes[s] = charge;
                        mdl_stamp[s] = mdl_clock;
                        mdl_clock    = mdl_clock + 64'd1;
                        mdl_total    = mdl_total + 39'(charge);
                    end
                    push_result(1'b1, 1'b0, 64'd0, charge, 1'b1);
                end
            end
            KIND_GET, KIND_PROBE:
            begin
                s = lookup_slot(k);
                if (s < 0)
                    push_result(1'b0, 1'b0, 64'd0, 33'd0, 1'b1);
                else
                begin
                    if (op == KIND_GET)
                    begin
                        mdl_stamp[s] = mdl_clock;
                        mdl_clock    = mdl_clock + 64'd1;
                    end
                    push_result(1'b1, 1'b0, 64'd0, mdl_bytes[s], 1'b1);
                end
            end
            KIND_REMOVE:
            begin
                s = lookup_slot(k);
                if (s < 0)
                    push_result(1'b0, 1'b0, 64'd0, 33'd0, 1'b1);
                else
                begin
                    held         = mdl_bytes[s];
                    mdl_total    = mdl_total - 39'(held);
                    mdl_valid[s] = 1'b0;
                    push_result(1'b1, 1'b0, 64'd0, held, 1'b1);
                end
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    mdl_valid[i] = 1'b0;
                mdl_total = 39'd0;
                push_result(1'b1, 1'b0, 64'd0, 33'd0, 1'b1);
            end
            default:
                push_result(1'b0, 1'b0, 64'd0, 33'd0, 1'b1);
        endcase
    endtask

    function automatic op_row_t make_row(bit [2:0] op, bit [63:0] k, bit [12:0] klen,
                                         bit [31:0] plen, bit typed, bit r_ok,
                                         bit [32:0] r_bytes);
        op_row_t r;
        r.kind           = op;
        r.key            = k;
        r.key_length     = klen;
        r.payload_length = plen;
        r.typed          = typed;
        r.ok             = r_ok;
        r.entry_bytes    = r_bytes;
        return r;
    endfunction

    // The channel offers one transaction and holds it steady until it is taken.
    // A random gap may come first.  The model is updated only at acceptance.
    task automatic send_op(op_row_t r);
        cache_result_t typed_res;
        if ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_gap_pct);
        end
        in_valid       <= 1'b1;
        kind           <= r.kind;
        key            <= r.key;
        key_length     <= r.key_length;
        payload_length <= r.payload_length;
        do
            @(posedge clk);
        while (in_stall);
        apply_cache_op(r.kind, r.key, r.key_length, r.payload_length);
        if (r.typed)
        begin
            // Rows with a written-in answer cause exactly one result.  Here that
            // answer replaces the one the model queued, but the model state update
            // is kept.
            void'(pending_results.pop_back());
            typed_res.ok          = r.ok;
            typed_res.evicted     = 1'b0;
            typed_res.evicted_key = 64'd0;
            typed_res.entry_bytes = r.entry_bytes;
            typed_res.total_bytes = 39'd0;
            typed_res.entry_count = 6'd0;
            typed_res.last        = 1'b1;
            pending_results.push_back(typed_res);
        end
    endtask

    // The budget changes only when the block is idle.  The sender first waits
    // until all results are in, then gives the block time to finish its last step.
    task automatic set_budget(bit [39:0] value);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (100) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        mdl_budget  = value;
    endtask

    function automatic op_row_t random_op(bit [39:0] budget);
        op_row_t r;
        int      pick;
        pick = $urandom_range(99);
        if (pick < 45)
            r.kind = KIND_PUT;
        else if (pick < 65)
            r.kind = KIND_GET;
        else if (pick < 77)
            r.kind = KIND_PROBE;
        else if (pick < 90)
            r.kind = KIND_REMOVE;
        else if (pick < 94)
            r.kind = KIND_CLEAR;
        else
            r.kind = 3'($urandom_range(7));
        // Keys mostly come from a small pool, so hits, replacements and evictions
        // all happen.
        if ($urandom_range(9) < 8)
            r.key = key_pool[$urandom_range(KEY_POOL - 1)];
        else
            r.key = {$urandom, $urandom};
        if ($urandom_range(9) < 8)
            r.key_length = 13'($urandom_range(64));
        else
            r.key_length = 13'($urandom);
        // Payloads are kept in proportion to a small budget, so that puts evict.
        // Occasionally a full-range length is used, which is oversized under any
        // small budget.
        if ($urandom_range(9) < 8)
            r.payload_length = (budget != 0 && budget < 40'd10000) ?
                               32'($urandom_range(400)) : 32'($urandom_range(5000));
        else
            r.payload_length = $urandom;
        r.typed       = 1'b0;
        r.ok          = 1'b0;
        r.entry_bytes = 33'd0;
        return r;
    endfunction

    // The receiver checks each result transaction against the oldest expected
    // one, and then decides whether to stall the next cycle.
    always @(posedge clk)
    begin
        cache_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction arrived with nothing expected");
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (ok !== e.ok)
                begin
                    $error("ok: expected %0d, actual %0d", e.ok, ok);
                    error_count++;
                end
                if (evicted !== e.evicted)
                begin
                    $error("evicted: expected %0d, actual %0d", e.evicted, evicted);
                    error_count++;
                end
                if (evicted_key !== e.evicted_key)
                begin
                    $error("evicted_key: expected %h, actual %h", e.evicted_key,
                           evicted_key);
                    error_count++;
                end
                if (entry_bytes !== e.entry_bytes)
                begin
                    $error("entry_bytes: expected %0d, actual %0d", e.entry_bytes,
                           entry_bytes);
                    error_count++;
                end
                if (total_bytes !== e.total_bytes)
                begin
                    $error("total_bytes: expected %0d, actual %0d", e.total_bytes,
                           total_bytes);
                    error_count++;
                end
                if (entry_count !== e.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d", e.entry_count,
                           entry_count);
                    error_count++;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0d, actual %0d", e.last, last);
                    error_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // This watchdog counts cycles with no transaction on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("byte_budget_lru_cache_index_top verification failed");
            $finish;
        end
    end

    initial
    begin
        bit [39:0] budgets [6];
        int        items_per_phase;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = KIND_PUT;
        key            = 64'd0;
        key_length     = 13'd0;
        payload_length = 32'd0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 40'd0;
        error_count    = 0;
        quiet_cycles   = 0;
        send_gap_pct   = 20;
        recv_stall_pct = 63;
        mdl_clock      = 64'd0;
        mdl_total      = 39'd0;
        mdl_budget     = 40'd0;
        for (int i = 0; i < SLOTS; i++)
            mdl_valid[i] = 1'b0;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = 64'd0;
        key_pool[1] = '1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.  At first the index is empty and the budget is unlimited,
        // so misses, unused kinds and rejected puts report zero totals.  A long key
        // is rejected with its full charge.  A clear always reports zero.
        op_table.push_back(make_row(KIND_GET, 64'd0, 13'd0, 32'd0, 1, 0, 33'd0));
        op_table.push_back(make_row(KIND_PROBE, '1, 13'd0, 32'd0, 1, 0, 33'd0));
        op_table.push_back(make_row(KIND_REMOVE, '1, 13'd0, 32'd0, 1, 0, 33'd0));
        op_table.push_back(make_row(KIND_SPARE_5, 64'd0, 13'd0, 32'd0, 1, 0, 33'd0));
        op_table.push_back(make_row(KIND_SPARE_6, '1, '1, '1, 1, 0, 33'd0));
        op_table.push_back(make_row(KIND_SPARE_7, 64'd5, 13'd3, 32'd9, 1, 0, 33'd0));
        op_table.push_back(make_row(KIND_PUT, '1, 13'd4097, '1, 1, 0, 33'd4294971396));
        op_table.push_back(make_row(KIND_PUT, 64'd7, '1, 32'd0, 1, 0, 33'd8195));
        op_table.push_back(make_row(KIND_PUT, '1, 13'd4096, '1, 0, 0, 33'd0));
        op_table.push_back(make_row(KIND_PUT, 64'd0, 13'd0, 32'd0, 0, 0, 33'd0));
        op_table.push_back(make_row(KIND_PUT, 64'h5555_5555_5555_5555, 13'd8, 32'd100,
                                    0, 0, 33'd0));
        op_table.push_back(make_row(KIND_GET, 64'd0, 13'd0, 32'd0, 0, 0, 33'd0));
        op_table.push_back(make_row(KIND_PROBE, '1, 13'd0, 32'd0, 0, 0, 33'd0));
        op_table.push_back(make_row(KIND_REMOVE, 64'd0, 13'd0, 32'd0, 0, 0, 33'd0));
        op_table.push_back(make_row(KIND_GET, 64'd0, 13'd0, 32'd0, 0, 0, 33'd0));
        op_table.push_back(make_row(KIND_PUT, '1, 13'd1, 32'd1, 0, 0, 33'd0));
        op_table.push_back(make_row(KIND_GET, '1, 13'd0, 32'd0, 0, 0, 33'd0));
        op_table.push_back(make_row(KIND_CLEAR, 64'd0, 13'd0, 32'd0, 1, 1, 33'd0));
        op_table.push_back(make_row(KIND_GET, '1, 13'd0, 32'd0, 1, 0, 33'd0));
        foreach (op_table[i])
            send_op(op_table[i]);

        // Random part.  Budget phases cover unlimited, tight, the smallest value
        // (every put rejected) and the largest value.  The idling pattern changes
        // every two phases.
        budgets[0] = 40'd0;
        budgets[1] = 40'd2000;
        budgets[2] = 40'd1;
        budgets[3] = 40'd600;
        budgets[4] = '1;
        budgets[5] = {8'($urandom_range(255)), 32'($urandom)} | 40'h80_0000_0000;
        items_per_phase = 44;
        for (int p = 0; p < 6; p++)
        begin
            if (p == 2)
            begin
                send_gap_pct   = 63;
                recv_stall_pct = 20;
            end
            else if (p == 4)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            set_budget(budgets[p]);
            for (int n = 0; n < items_per_phase; n++)
                send_op(random_op(budgets[p]));
        end
        in_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("byte_budget_lru_cache_index_top verification clean");
        else
            $display("byte_budget_lru_cache_index_top verification failed");
        $finish;
    end

endmodule
